[rtl/bbpt_pkg.sv]
// Shared types, constants and helper functions of the basis blade product term block.
`default_nettype none

package bbpt_pkg;

    localparam int unsigned C_MASK_W  = 8;
    localparam int unsigned C_COEF_W  = 16;
    localparam int unsigned C_DIM_W   = 4;
    localparam int unsigned C_GRADE_W = 4;
    localparam int unsigned C_RANK_W  = 7;
    localparam int unsigned C_TERM_W  = 32;
    localparam int unsigned C_ADDR_W  = 3;
    localparam int unsigned C_DATA_W  = 32;

    // Largest number of basis vectors the hardware supports.
    localparam logic [C_DIM_W-1:0] C_MAX_DIM   = 4'd8;
    localparam logic [C_DIM_W-1:0] C_MIN_DIM   = 4'd1;
    localparam logic [C_DIM_W-1:0] C_DIM_RESET = 4'd8;

    // Register index as decoded from paddr[2].
    localparam logic C_REG_DIMENSION = 1'b0;

    // Largest rank any blade can have (four of eight).
    localparam logic [C_RANK_W-1:0] C_MAX_RANK = 7'd69;

    typedef struct packed {
        logic        [C_MASK_W-1:0] mask_a;
        logic        [C_MASK_W-1:0] mask_b;
        logic signed [C_COEF_W-1:0] coef_a;
        logic signed [C_COEF_W-1:0] coef_b;
    } t_bbpt_in;

    typedef struct packed {
        logic        [C_MASK_W-1:0]  product_mask;
        logic        [C_GRADE_W-1:0] result_grade;
        logic        [C_RANK_W-1:0]  index_in_grade;
        logic                        negated;
        logic signed [C_TERM_W-1:0]  term_value;
    } t_bbpt_out;

    // Binomial coefficients C(n, r) for n, r in 0..7, row n at [n].
    typedef logic [C_RANK_W-1:0] t_choose_row [0:7];
    typedef t_choose_row         t_choose_tab [0:7];

    localparam t_choose_tab C_CHOOSE = '{
        '{7'd1, 7'd0, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd2, 7'd1,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd3, 7'd3,  7'd1,  7'd0,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd4, 7'd6,  7'd4,  7'd1,  7'd0,  7'd0, 7'd0},
        '{7'd1, 7'd5, 7'd10, 7'd10, 7'd5,  7'd1,  7'd0, 7'd0},
        '{7'd1, 7'd6, 7'd15, 7'd20, 7'd15, 7'd6,  7'd1, 7'd0},
        '{7'd1, 7'd7, 7'd21, 7'd35, 7'd35, 7'd21, 7'd7, 7'd1}
    };

    function automatic logic [C_RANK_W-1:0] f_choose(input logic [2:0] n, input logic [2:0] r);
        return C_CHOOSE[n][r];
    endfunction

    function automatic logic [C_GRADE_W-1:0] f_ones8(input logic [C_MASK_W-1:0] v);
        logic [C_GRADE_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < C_MASK_W; i++) begin
            cnt = cnt + C_GRADE_W'(v[i]);
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

[rtl/basis_blade_product_term.sv]
// Top level of the basis blade product term block: one geometric product term per transfer.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_bbpt_in)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_bbpt_out)
//  config  | input     | APB psel/penable/pready | dimension register at byte address 0
//
// The block takes one input transfer per clock cycle while the output is not stalled. An item
// is captured in the input register and moves on into the result register once that is free,
// which raises o_out_valid; the result transfer follows when i_out_ready is high.
// Throughput is one term per cycle while the output does not stall, set by the single
// combinational pass between the two registers. Reset (synchronous, active low) empties both
// registers and sets dimension to 8. A stalled output holds the result register; the input
// register still takes one more transfer, so input and output stalls are decoupled by one item.
`default_nettype none

module basis_blade_product_term (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  bbpt_pkg::t_bbpt_in         i_in_data,
    // Output channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output bbpt_pkg::t_bbpt_out              o_out_data,
    // Configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bbpt_pkg::C_ADDR_W-1:0]    paddr,
    input  wire  [bbpt_pkg::C_DATA_W-1:0]    pwdata,
    output logic [bbpt_pkg::C_DATA_W-1:0]    prdata,
    output logic                             pready
);

    import bbpt_pkg::*;

    // Configuration register.
    logic [C_DIM_W-1:0] r_dim;
    logic [C_DIM_W-1:0] n_dim;
    logic               cfg_wr;

    // Pipeline registers and their next values.
    logic      r_s1_valid;
    logic      n_s1_valid;
    t_bbpt_in  r_s1_data;
    logic      r_out_valid;
    logic      n_out_valid;
    t_bbpt_out r_out_data;
    t_bbpt_out n_out_data;

    logic      s1_load;
    logic      out_free;
    logic      out_load;

    // Datapath signals of the single pass.
    logic [C_DIM_W-1:0]   dim_eff;
    logic [C_MASK_W-1:0]  keep;
    logic [C_MASK_W-1:0]  ma;
    logic [C_MASK_W-1:0]  mb;
    logic [C_MASK_W-1:0]  pm;
    logic [C_GRADE_W-1:0] grade;
    logic [C_GRADE_W-1:0] seen;
    logic [C_RANK_W-1:0]  rank;
    logic                 flip;
    logic signed [C_TERM_W-1:0] prod;

    // ------------------------------------------------------------------
    // Configuration port. A write completes in the access phase; pready is
    // tied high so there are no wait states. Writes to the upper word are
    // outside the register map and are dropped.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == C_REG_DIMENSION);
    assign n_dim  = cfg_wr ? pwdata[C_DIM_W-1:0] : r_dim;

    always_comb begin
        prdata = '0;
        if (paddr[2] == C_REG_DIMENSION) begin
            prdata = C_DATA_W'(r_dim);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register frees up when it is empty or being
    // read; the input register frees up when it is empty or moving on.
    // ------------------------------------------------------------------
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || out_free;
    assign s1_load     = i_in_valid && o_in_ready;

    assign n_s1_valid  = s1_load || (r_s1_valid && !out_free);
    assign n_out_valid = out_load || (r_out_valid && !i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Single combinational pass from the input register.
    // ------------------------------------------------------------------

    // Out-of-range dimension values are clamped to 1..8.
    always_comb begin
        if (r_dim < C_MIN_DIM) begin
            dim_eff = C_MIN_DIM;
        end else if (r_dim > C_MAX_DIM) begin
            dim_eff = C_MAX_DIM;
        end else begin
            dim_eff = r_dim;
        end
    end

    // Mask bits at or above the dimension are ignored everywhere.
    always_comb begin
        for (int v = 0; v < C_MASK_W; v++) begin
            keep[v] = (C_DIM_W'(v) < dim_eff);
        end
    end

    assign ma    = r_s1_data.mask_a & keep;
    assign mb    = r_s1_data.mask_b & keep;
    assign pm    = ma ^ mb;
    assign grade = f_ones8(pm);

    // Lexicographic rank: walking up from e_0, every absent basis vector that
    // comes before all chosen ones are placed skips C(remaining, still needed)
    // combinations. Eight narrow steps with a table lookup each.
    always_comb begin
        seen = '0;
        rank = '0;
        for (int v = 0; v < C_MASK_W; v++) begin
            if (keep[v]) begin
                if (pm[v]) begin
                    seen = seen + C_GRADE_W'(1);
                end else if (seen < grade) begin
                    rank = rank + f_choose(3'(dim_eff - C_DIM_W'(1) - C_DIM_W'(v)),
                                           3'(grade - C_GRADE_W'(1) - seen));
                end
            end
        end
    end

    // Reordering sign: parity of pairs (a in A, b in B) with a > b. For each
    // b the parity of the A bits above it is an XOR reduction, so the lanes
    // are independent.
    always_comb begin
        flip = 1'b0;
        for (int v = 0; v < C_MASK_W; v++) begin
            flip = flip ^ (mb[v] & (^(ma >> (v + 1))));
        end
    end

    // Q1.15 times Q1.15 gives Q2.30; the magnitude never exceeds 2^30, so the
    // negation cannot overflow 32 bits.
    assign prod = r_s1_data.coef_a * r_s1_data.coef_b;

    always_comb begin
        n_out_data.product_mask   = pm;
        n_out_data.result_grade   = grade;
        n_out_data.index_in_grade = rank;
        n_out_data.negated        = flip;
        n_out_data.term_value     = flip ? -prod : prod;
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= C_DIM_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dim       <= n_dim;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_data <= i_in_data;
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTH
    // The grade shown always matches the blade shown.
    a_grade_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.result_grade == $countones(o_out_data.product_mask)))
        else $error("result_grade does not match popcount of product_mask");

    // No blade of eight basis vectors ranks beyond the middle row's count.
    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.index_in_grade <= C_MAX_RANK))
        else $error("index_in_grade out of range");

    // An item in the input register moves to the result register when it is free.
    a_item_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> o_out_valid)
        else $error("item in input register did not reach the result register");

    // The result register is never overwritten while it waits to be taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("result register changed while stalled");
`endif

endmodule

`default_nettype wire
